FILE: hdl/x86_instruction_relocator_macros.svh
// Assertion macros used by the relocator back end.
`ifndef X86_INSTRUCTION_RELOCATOR_MACROS_SVH
`define X86_INSTRUCTION_RELOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define XIR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define XIR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error("assertion failed");
`else
`define XIR_ASSERT(label, clk, rst_n, prop)
`define XIR_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: hdl/xir_pkg.sv
// Shared types and constants of the instruction relocator.
package xir_pkg;
  localparam int MAX_INSTR_BYTES = 8;
  localparam int QDEPTH = 4;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_SMALL = 2'd2;
  localparam logic [1:0] CFG_SOURCE_BASE = 2'd0;
  localparam logic [1:0] CFG_DEST_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_SOURCE_END = 2'd2;
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_COPY = 2'd1;
  localparam logic [1:0] K_SEQ = 2'd2;
  localparam logic [1:0] K_ERR = 2'd3;
  localparam int SEQ_LEN = 18;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [4:0] len;
    logic [7:0][7:0] bytes_a;
    logic [9:0][7:0] bytes_b;
    logic [63:0] limit;
  } job_t;

  function automatic logic [63:0] sext8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction
endpackage

FILE: hdl/xir_if.sv
// Valid/ready channel interface carrying one payload.
interface xir_if #(parameter int W = 8) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/xir_front.sv
// Front end: decodes code bytes and issues one job per finished or rejected instruction.
module xir_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_vld,
  input  logic [7:0]  code_byte,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata,
  output logic        job_vld,
  output xir_pkg::job_t job
);
  localparam logic [3:0] PH_START = 4'd0, PH_OPCODE = 4'd1, PH_MODRM_SUB = 4'd2,
    PH_MODRM_MOV = 4'd3, PH_SIB = 4'd4, PH_TAIL = 4'd5, PH_MODRM_CMP = 4'd6,
    PH_CMP_TAIL = 4'd7, PH_JCC_DISP = 4'd8;

  logic [3:0] phase_r, phase_nxt;
  logic [7:0] prefix_r, prefix_nxt, opcode_r, opcode_nxt;
  logic [3:0] pend_r, pend_nxt;
  logic [7:0][7:0] ib_r, ib_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [31:0] disp_r, disp_nxt, imm_r, imm_nxt;
  logic [63:0] off_r, base_r, send_r, send_nxt;
  logic [9:0] cap_r, used_r, used_nxt;
  logic [63:0] off1, addr;
  logic [2:0] cidx;
  logic [4:0] len;
  logic [10:0] tot;
  xir_pkg::job_t j;

  assign off1 = off_r + 64'd1;

  always_comb begin
    logic [7:0] op;
    logic [7:0] rex;
    logic [1:0] md;
    phase_nxt = phase_r; prefix_nxt = prefix_r; opcode_nxt = opcode_r; pend_nxt = pend_r;
    ib_nxt = ib_r; cnt_nxt = cnt_r; disp_nxt = disp_r; imm_nxt = imm_r;
    send_nxt = send_r; used_nxt = used_r; addr = 64'd0; cidx = 3'd0; len = 5'd0;
    op = code_byte; rex = prefix_r; md = code_byte[7:6]; tot = 11'd0;
    j = '0;
    j.kind = xir_pkg::K_NONE;
    if (phase_r == PH_START) begin
      cnt_nxt = 4'd0;
      rex = 8'd0;
    end
    if (phase_r <= PH_TAIL) begin
      if (cnt_nxt < 4'd8) ib_nxt[cnt_nxt[2:0]] = code_byte;
      if (cnt_nxt < 4'd8) cnt_nxt = cnt_nxt + 4'd1;
    end
    case (phase_r)
      PH_START, PH_OPCODE: begin
        if (phase_r == PH_START && code_byte[7:4] == 4'h4) begin
          prefix_nxt = code_byte;
          phase_nxt = PH_OPCODE;
        end else begin
          if (phase_r == PH_START) prefix_nxt = 8'd0;
          opcode_nxt = op;
          phase_nxt = PH_START;
          pend_nxt = 4'd0;
          if ((rex == 8'h00 || rex == 8'h41) && op[7:4] == 4'h5) j.kind = xir_pkg::K_COPY;
          else if (rex == 8'h48 && op == 8'h81) phase_nxt = PH_MODRM_SUB;
          else if (rex == 8'h48 && op == 8'h89) phase_nxt = PH_MODRM_MOV;
          else if (rex == 8'h00 && op[7:3] == 5'b10111) begin
            pend_nxt = 4'd4; phase_nxt = PH_TAIL;
          end else if (rex == 8'h00 && op == 8'h81) phase_nxt = PH_MODRM_CMP;
          else if (rex == 8'h00 && op[7:4] == 4'h7) phase_nxt = PH_JCC_DISP;
          else j.kind = xir_pkg::K_ERR;
        end
      end
      PH_MODRM_SUB: begin
        if (code_byte != 8'hEC) j.kind = xir_pkg::K_ERR;
        else begin pend_nxt = 4'd4; phase_nxt = PH_TAIL; end
      end
      PH_MODRM_MOV: begin
        if (code_byte == 8'hE5) j.kind = xir_pkg::K_COPY;
        else if (code_byte[2:0] != 3'd4 || (md != 2'd1 && md != 2'd2)) j.kind = xir_pkg::K_ERR;
        else begin
          pend_nxt = (md == 2'd1) ? 4'd1 : 4'd4; phase_nxt = PH_SIB;
        end
      end
      PH_SIB: phase_nxt = PH_TAIL;
      PH_TAIL: begin
        if (pend_r != 4'd0) pend_nxt = pend_r - 4'd1;
        if (pend_nxt == 4'd0) j.kind = xir_pkg::K_COPY;
      end
      PH_MODRM_CMP: begin
        if (code_byte != 8'h3D) j.kind = xir_pkg::K_ERR;
        else begin
          disp_nxt = 32'd0; imm_nxt = 32'd0; pend_nxt = 4'd8; phase_nxt = PH_CMP_TAIL;
        end
      end
      PH_CMP_TAIL: begin
        cidx = 3'(4'd8 - pend_r);
        if (!cidx[2]) disp_nxt[cidx[1:0]*8 +: 8] = code_byte;
        else imm_nxt[cidx[1:0]*8 +: 8] = code_byte;
        if (pend_r != 4'd0) pend_nxt = pend_r - 4'd1;
        if (pend_nxt == 4'd0) begin
          addr = base_r + off1 + {{32{disp_nxt[31]}}, disp_nxt};
          j.kind = xir_pkg::K_SEQ;
          j.bytes_a = {addr[39:0], 8'hb8, 8'h48, 8'h50};
          j.bytes_b = {8'h58, imm_nxt, 8'h38, 8'h81, addr[63:40]};
        end
      end
      PH_JCC_DISP: begin
        addr = base_r + off1 + xir_pkg::sext8(code_byte);
        if (addr < send_r) send_nxt = addr;
        j.kind = xir_pkg::K_SEQ;
        j.bytes_a = {8'h00, 8'h00, 8'h25, 8'hff, 8'h0e, 8'heb, 8'h02, opcode_r};
        j.bytes_b = {addr, 8'h00, 8'h00};
      end
      default: j.kind = xir_pkg::K_ERR;
    endcase
    if (j.kind != xir_pkg::K_NONE) begin
      phase_nxt = PH_START;
      pend_nxt = 4'd0;
      len = (j.kind == xir_pkg::K_SEQ) ? 5'(xir_pkg::SEQ_LEN) : {1'b0, cnt_nxt};
      if (j.kind == xir_pkg::K_COPY) j.bytes_a = ib_nxt;
      tot = {1'b0, used_r} + {6'd0, len};
      if (j.kind == xir_pkg::K_ERR) begin
        j.status = xir_pkg::ST_UNSUP; j.len = 5'd1;
      end else if (tot > {1'b0, cap_r}) begin
        j.kind = xir_pkg::K_ERR; j.status = xir_pkg::ST_SMALL; j.len = 5'd1;
      end else begin
        j.status = xir_pkg::ST_OK; j.len = len; used_nxt = tot[9:0];
      end
    end
    j.limit = send_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START; prefix_r <= '0; opcode_r <= '0; pend_r <= '0; cnt_r <= '0;
      disp_r <= '0; imm_r <= '0; off_r <= '0; used_r <= '0; base_r <= '0;
      cap_r <= 10'd64; send_r <= '0; job_vld <= 1'b0;
    end else begin
      job_vld <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          xir_pkg::CFG_SOURCE_BASE: base_r <= cfg_wdata;
          xir_pkg::CFG_DEST_CAPACITY: cap_r <= cfg_wdata[9:0];
          xir_pkg::CFG_SOURCE_END: send_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (byte_vld) begin
        phase_r <= phase_nxt; prefix_r <= prefix_nxt; opcode_r <= opcode_nxt;
        pend_r <= pend_nxt; cnt_r <= cnt_nxt; disp_r <= disp_nxt; imm_r <= imm_nxt;
        off_r <= off1; used_r <= used_nxt; send_r <= send_nxt;
        job_vld <= (j.kind != xir_pkg::K_NONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld) begin
      ib_r <= ib_nxt;
      job <= j;
    end
  end
endmodule

FILE: hdl/xir_back.sv
// Back end: job queue and serializer that emits one result byte per transfer.
module xir_back #(
  parameter int QDEPTH = xir_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_vld,
  input  xir_pkg::job_t job,
  output logic        space_ok,
  xir_if.source       out_ch
);
  `include "x86_instruction_relocator_macros.svh"
  localparam int AW = $clog2(QDEPTH);
  xir_pkg::job_t mem [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic [4:0] pos_r;
  xir_pkg::job_t cur;
  logic last, pop;
  logic [17:0][7:0] seq;

  assign cur = mem[rp_r];
  assign seq = {cur.bytes_b, cur.bytes_a};
  assign last = (pos_r + 5'd1 == cur.len);
  assign pop = out_ch.valid && out_ch.ready && last;
  // A free slot is guaranteed for the job that an accepted byte may raise.
  assign space_ok = (cnt_r < (AW+1)'(QDEPTH - 1)) || ((cnt_r < (AW+1)'(QDEPTH)) && !job_vld);
  assign out_ch.valid = (cnt_r != '0);
  assign out_ch.data = {cur.limit, last,
                        cur.status, (cur.kind == xir_pkg::K_ERR) ? 8'd0 : seq[pos_r]};

  always_ff @(posedge clk) begin
    if (job_vld) mem[wp_r] <= job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; pos_r <= '0;
    end else begin
      if (job_vld) wp_r <= (wp_r == AW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == AW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(job_vld) - (AW+1)'(pop);
      if (out_ch.valid && out_ch.ready) pos_r <= last ? 5'd0 : pos_r + 5'd1;
    end
  end

  `XIR_ASSERT(a_no_overflow, clk, rst_n, !(job_vld && cnt_r == (AW+1)'(QDEPTH) && !pop))
  `XIR_ASSERT(a_pos_in_range, clk, rst_n, !out_ch.valid || pos_r < cur.len)
  `XIR_ASSERT_NEXT(a_pop_resets_pos, clk, rst_n, pop, pos_r == 5'd0)
endmodule

FILE: hdl/x86_instruction_relocator.sv
// Top level of the x86-64 instruction relocator.
// A result's first byte is offered once its job is registered by the front and queued by the back.
// Throughput: one code byte per cycle; one result byte per cycle from the queue while ready.
// An 18-byte sequence is sent as 18 transfers; the input stalls when the queue fills.
// Reset is synchronous and active low; it clears control state but not the job or queue storage.
module x86_instruction_relocator #(
  parameter int QDEPTH = xir_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  xir_if.sink         in_ch,
  xir_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);
  logic job_vld, space_ok;
  xir_pkg::job_t job;

  assign in_ch.ready = space_ok;

  xir_front u_front (
    .clk, .rst_n, .byte_vld(in_ch.valid && in_ch.ready), .code_byte(in_ch.data),
    .cfg_we, .cfg_idx, .cfg_wdata, .job_vld, .job
  );

  xir_back #(.QDEPTH(QDEPTH)) u_back (
    .clk, .rst_n, .job_vld, .job, .space_ok, .out_ch
  );
endmodule

FILE: tb/tb_x86_instruction_relocator.sv
// Testbench for the x86-64 instruction relocator: a byte-level decoder model checks every result.
`timescale 1ns / 1ps

module tb_x86_instruction_relocator;
  typedef struct packed {
    logic [63:0] limit;
    logic        last;
    logic [1:0]  status;
    logic [7:0]  code;
  } reloc_res_t;

  typedef enum logic [3:0] {
    DP_START, DP_OPCODE, DP_MODRM_SUB, DP_MODRM_MOV, DP_SIB, DP_TAIL,
    DP_MODRM_CMP, DP_CMP_TAIL, DP_JCC_DISP
  } dec_phase_t;

  localparam int RES_W = $bits(reloc_res_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = xir_pkg::CFG_SOURCE_BASE;
  logic [63:0] cfg_wdata = '0;

  xir_if #(.W(8)) in_ch (clk);
  xir_if #(.W(RES_W)) out_ch (clk);

  x86_instruction_relocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  logic [7:0]  code_q[$];
  reloc_res_t  reloc_q[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  bit          calm = 1'b0;

  // Decoder model state.
  logic [63:0] m_base = '0;
  logic [9:0]  m_cap = 10'd64;
  logic [63:0] m_end = '0;
  dec_phase_t  m_phase = DP_START;
  logic [7:0]  m_prefix = '0;
  logic [7:0]  m_opcode = '0;
  logic [3:0]  m_pend = '0;
  logic [7:0]  m_ibuf[xir_pkg::MAX_INSTR_BYTES];
  int          m_icnt = 0;
  logic [31:0] m_disp = '0;
  logic [31:0] m_imm = '0;
  logic [63:0] m_soff = '0;
  logic [9:0]  m_used = '0;

  task automatic push_res(logic [7:0] b, logic [1:0] st, logic l);
    reloc_res_t r;
    r.code = b; r.status = st; r.last = l; r.limit = m_end;
    reloc_q.push_back(r);
  endtask

  task automatic decode_error(logic [1:0] st);
    m_phase = DP_START;
    m_pend = '0;
    push_res(8'h00, st, 1'b1);
  endtask

  task automatic emit_seq(logic [7:0] seq[18], int len);
    m_phase = DP_START;
    m_pend = '0;
    if (int'(m_used) + len > int'(m_cap)) begin
      decode_error(xir_pkg::ST_SMALL);
    end else begin
      for (int k = 0; k < len; k++) push_res(seq[k], xir_pkg::ST_OK, k + 1 == len);
      m_used = m_used + 10'(len);
    end
  endtask

  task automatic emit_copy();
    logic [7:0] seq[18];
    for (int k = 0; k < 18; k++) seq[k] = (k < xir_pkg::MAX_INSTR_BYTES) ? m_ibuf[k] : 8'h00;
    emit_seq(seq, m_icnt);
  endtask

  task automatic keep_byte(logic [7:0] b);
    if (m_icnt < xir_pkg::MAX_INSTR_BYTES) m_ibuf[m_icnt] = b;
    m_icnt++;
    if (m_icnt > xir_pkg::MAX_INSTR_BYTES) m_icnt = xir_pkg::MAX_INSTR_BYTES;
  endtask

  task automatic take_opcode(logic [7:0] op);
    m_opcode = op;
    if ((m_prefix == 8'h00 || m_prefix == 8'h41) && op[7:4] == 4'h5) emit_copy();
    else if (m_prefix == 8'h48 && op == 8'h81) m_phase = DP_MODRM_SUB;
    else if (m_prefix == 8'h48 && op == 8'h89) m_phase = DP_MODRM_MOV;
    else if (m_prefix == 8'h00 && op[7:3] == 5'b10111) begin
      m_pend = 4'd4; m_phase = DP_TAIL;
    end else if (m_prefix == 8'h00 && op == 8'h81) m_phase = DP_MODRM_CMP;
    else if (m_prefix == 8'h00 && op[7:4] == 4'h7) m_phase = DP_JCC_DISP;
    else decode_error(xir_pkg::ST_UNSUP);
  endtask

  task automatic relocate_byte(logic [7:0] b);
    logic [7:0] seq[18];
    logic [63:0] addr;
    int idx;
    m_soff = m_soff + 64'd1;
    case (m_phase)
      DP_START: begin
        m_icnt = 0;
        keep_byte(b);
        if (b[7:4] == 4'h4) begin
          m_prefix = b; m_phase = DP_OPCODE;
        end else begin
          m_prefix = 8'h00; take_opcode(b);
        end
      end
      DP_OPCODE: begin
        keep_byte(b); take_opcode(b);
      end
      DP_MODRM_SUB: begin
        keep_byte(b);
        if (b != 8'hEC) decode_error(xir_pkg::ST_UNSUP);
        else begin m_pend = 4'd4; m_phase = DP_TAIL; end
      end
      DP_MODRM_MOV: begin
        keep_byte(b);
        if (b == 8'hE5) emit_copy();
        else if (b[2:0] != 3'd4 || (b[7:6] != 2'd1 && b[7:6] != 2'd2)) begin
          decode_error(xir_pkg::ST_UNSUP);
        end else begin
          m_pend = (b[7:6] == 2'd1) ? 4'd1 : 4'd4; m_phase = DP_SIB;
        end
      end
      DP_SIB: begin
        keep_byte(b); m_phase = DP_TAIL;
      end
      DP_TAIL: begin
        keep_byte(b);
        if (m_pend > 0) m_pend--;
        if (m_pend == 0) emit_copy();
      end
      DP_MODRM_CMP: begin
        if (b != 8'h3D) decode_error(xir_pkg::ST_UNSUP);
        else begin
          m_disp = '0; m_imm = '0; m_pend = 4'd8; m_phase = DP_CMP_TAIL;
        end
      end
      DP_CMP_TAIL: begin
        idx = (8 - int'(m_pend)) & 7;
        if (idx < 4) m_disp[8*idx +: 8] = b;
        else m_imm[8*(idx-4) +: 8] = b;
        if (m_pend > 0) m_pend--;
        if (m_pend == 0) begin
          addr = m_base + m_soff + {{32{m_disp[31]}}, m_disp};
          seq[0] = 8'h50; seq[1] = 8'h48; seq[2] = 8'hb8;
          for (int i = 0; i < 8; i++) seq[3+i] = addr[8*i +: 8];
          seq[11] = 8'h81; seq[12] = 8'h38;
          for (int i = 0; i < 4; i++) seq[13+i] = m_imm[8*i +: 8];
          seq[17] = 8'h58;
          emit_seq(seq, 18);
        end
      end
      DP_JCC_DISP: begin
        addr = m_base + m_soff + {{56{b[7]}}, b};
        if (addr < m_end) m_end = addr;
        seq[0] = m_opcode; seq[1] = 8'h02; seq[2] = 8'heb; seq[3] = 8'h0e;
        seq[4] = 8'hff; seq[5] = 8'h25;
        for (int i = 6; i < 10; i++) seq[i] = 8'h00;
        for (int i = 0; i < 8; i++) seq[10+i] = addr[8*i +: 8];
        emit_seq(seq, 18);
      end
      default: decode_error(xir_pkg::ST_UNSUP);
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        relocate_byte(in_ch.data);
        bytes_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (code_q.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= code_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    reloc_res_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (reloc_q.size() == 0) begin
          report_mismatch("unexpected transfer", got.limit, 64'd0);
        end else begin
          want = reloc_q.pop_front();
          if (got.code !== want.code) begin
            report_mismatch("out_byte", 64'(got.code), 64'(want.code));
          end
          if (got.status !== want.status) begin
            report_mismatch("status", 64'(got.status), 64'(want.status));
          end
          if (got.last !== want.last) begin
            report_mismatch("last", 64'(got.last), 64'(want.last));
          end
          if (got.limit !== want.limit) report_mismatch("source_limit", got.limit, want.limit);
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  task automatic wr_cfg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      xir_pkg::CFG_SOURCE_BASE: m_base = val;
      xir_pkg::CFG_DEST_CAPACITY: m_cap = val[9:0];
      xir_pkg::CFG_SOURCE_END: m_end = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (code_q.size() != 0 || in_ch.valid || reloc_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic push_bytes(int n, logic [31:0] v);
    for (int i = 0; i < n; i++) code_q.push_back(v[8*i +: 8]);
  endtask

  task automatic gen_instr();
    int kind;
    kind = $urandom_range(99);
    if (kind < 12) begin
      if ($urandom_range(1)) code_q.push_back(8'h41);
      code_q.push_back(8'h50 | 8'($urandom_range(15)));
    end else if (kind < 24) begin
      code_q.push_back(8'h48); code_q.push_back(8'h81); code_q.push_back(8'hEC);
      push_bytes(4, $urandom);
    end else if (kind < 40) begin
      code_q.push_back(8'h48); code_q.push_back(8'h89);
      if ($urandom_range(3) == 0) code_q.push_back(8'hE5);
      else begin
        logic md;
        md = 1'($urandom_range(1));
        code_q.push_back({md ? 2'd1 : 2'd2, 3'($urandom_range(7)), 3'd4});
        code_q.push_back(8'($urandom));
        push_bytes(md ? 1 : 4, $urandom);
      end
    end else if (kind < 52) begin
      code_q.push_back(8'hB8 | 8'($urandom_range(7)));
      push_bytes(4, $urandom);
    end else if (kind < 66) begin
      code_q.push_back(8'h81); code_q.push_back(8'h3D);
      push_bytes(4, $urandom); push_bytes(4, $urandom);
    end else if (kind < 84) begin
      code_q.push_back(8'h70 | 8'($urandom_range(15)));
      code_q.push_back(8'($urandom));
    end else if (kind < 92) begin
      code_q.push_back(8'($urandom));
    end else begin
      case ($urandom_range(3))
        0: begin code_q.push_back(8'h48); code_q.push_back(8'h81);
                 code_q.push_back(8'($urandom)); end
        1: begin code_q.push_back(8'h48); code_q.push_back(8'h89);
                 code_q.push_back(8'($urandom)); end
        2: begin code_q.push_back(8'h81); code_q.push_back(8'($urandom)); end
        default: begin code_q.push_back(8'h40 | 8'($urandom_range(15)));
                       code_q.push_back(8'($urandom)); end
      endcase
    end
  endtask

  task automatic random_phase(int n);
    int start;
    start = code_q.size();
    while (code_q.size() - start < n) gen_instr();
  endtask

  initial begin
    for (int i = 0; i < xir_pkg::MAX_INSTR_BYTES; i++) m_ibuf[i] = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wr_cfg(xir_pkg::CFG_DEST_CAPACITY, 64'd1023);
    wr_cfg(xir_pkg::CFG_SOURCE_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
    wr_cfg(xir_pkg::CFG_SOURCE_END, 64'hFFFF_FFFF_FFFF_FFFF);
    // Directed forms, error paths and the displacement extremes.
    code_q = {8'h50, 8'h41, 8'h5F, 8'h48, 8'h81, 8'hEC, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h48, 8'h89, 8'hE5, 8'h48, 8'h89, 8'h44, 8'h24, 8'h80,
              8'h48, 8'h89, 8'h04, 8'h48, 8'h40, 8'h75, 8'h80, 8'h7F, 8'h7F};
    drain();
    code_q = {8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h81, 8'h3D, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h78, 8'h56, 8'h34, 8'h12, 8'h81, 8'h00, 8'h48, 8'h81, 8'h00,
              8'h48, 8'h89, 8'h84, 8'h24, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF, 8'h00};
    drain();
    wr_cfg(xir_pkg::CFG_DEST_CAPACITY, 64'd0);
    code_q = {8'h50, 8'h72, 8'h10};
    drain();
    wr_cfg(xir_pkg::CFG_SOURCE_BASE, 64'h0);
    wr_cfg(xir_pkg::CFG_DEST_CAPACITY, 64'd64);
    wr_cfg(xir_pkg::CFG_SOURCE_END, 64'h0000_0000_0010_0000);
    random_phase(120);
    drain();
    wr_cfg(xir_pkg::CFG_SOURCE_BASE, {$urandom, $urandom});
    wr_cfg(xir_pkg::CFG_DEST_CAPACITY, 64'd1023);
    wr_cfg(xir_pkg::CFG_SOURCE_END, {$urandom, $urandom});
    calm = 1'b1;
    random_phase(80);
    drain();
    calm = 1'b0;
    wr_cfg(xir_pkg::CFG_DEST_CAPACITY, 64'($urandom_range(1023)));
    wr_cfg(xir_pkg::CFG_SOURCE_END, 64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(120);
    drain();
    $display("Covered %0d code bytes and %0d result transfers over several register settings.",
             bytes_sent, results_seen);
    if (mismatches == 0 && reloc_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results still expected.", reloc_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/xir_pkg.sv
hdl/xir_if.sv
hdl/xir_front.sv
hdl/xir_back.sv
hdl/x86_instruction_relocator.sv
tb/tb_x86_instruction_relocator.sv
